// ----- sv/cursor_array_list_assert.svh -----
// cursor_array_list_assert.svh: assertion macros shared by the list modules
// expects clk and arst_n in the scope of every use
`ifndef CURSOR_ARRAY_LIST_ASSERT_SVH
`define CURSOR_ARRAY_LIST_ASSERT_SVH

// same-cycle implication, off during reset
`define CAL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cursor_array_list assertion failed");

// next-cycle implication, off during reset
`define CAL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cursor_array_list assertion failed");

`endif

// ----- sv/cal_pkg.sv -----
// cal_pkg: shared types, codes and constants of the cursor array list
// no dependencies
package cal_pkg;

	localparam int CAPACITY_WORDS_DEF = 32;
	localparam int VALUE_W            = 32;
	localparam int COUNT_OUT_W        = 6;
	localparam int CMD_W              = 3;
	localparam int STATUS_W           = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_START   = 3'd0,
		CMD_ADVANCE = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_ATTACH  = 3'd3,
		CMD_REMOVE  = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_FULL    = 2'd1,
		ST_NO_ITEM = 2'd2
	} status_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    cur_zero;
		logic    cur_inc;
		logic    cur_end;
		logic    open_init;
		logic    close_init;
		logic    shift_run;
		logic    put;
		logic    cnt_dec;
		logic    status_set;
		status_t status;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic on_item;
		logic full;
		logic shift_done;
	} sts_t;

endpackage

// ----- sv/cursor_array_list.sv -----
// cursor_array_list: top level of the ordered word list with a cursor
// depends on cal_pkg, cal_ctrl, cal_dp (and cal_ram below it)
//
// channel   | handshake        | payload
// ----------+------------------+---------------------------------------------
// command   | start / busy     | command, value
// result    | done (strobe)    | current_value, item_count, has_current, status
//
// an item is taken when start is high and busy is low; busy stays high through done,
// so the next item waits for the result; after taking an item, start, advance,
// rejected and unused codes go to look and show; attach with no current item to put,
// look, show; insert or attach to open, shift, put, look, show; remove to close,
// shift, look, show; the shift moves one word per cycle, its last write done before
// it ends; arst_n clears count, cursor and control; the word memory holds no reset,
// and the result sits on its ports for the one done cycle and cannot be held off
module cursor_array_list #(
	parameter int CAPACITY_WORDS = cal_pkg::CAPACITY_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command side
	input  logic                            start,
	output logic                            busy,
	input  logic [cal_pkg::CMD_W-1:0]       command,
	input  logic [cal_pkg::VALUE_W-1:0]     value,
	// result side
	output logic                            done,
	output logic [cal_pkg::VALUE_W-1:0]     current_value,
	output logic [cal_pkg::COUNT_OUT_W-1:0] item_count,
	output logic                            has_current,
	output logic [cal_pkg::STATUS_W-1:0]    status
);
	import cal_pkg::*;

	// commands from the sequencer, status back from the datapath
	ctl_t ctl;
	sts_t sts;

	// sequencer: decides each command against count and cursor, then walks
	// open or close gap, store, memory read and result strobe
	cal_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.command(command),
		.sts    (sts),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	// datapath: count, cursor, word mover and the word memory itself
	cal_dp #(
		.CAPACITY_WORDS(CAPACITY_WORDS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.value        (value),
		.ctl          (ctl),
		.sts          (sts),
		.current_value(current_value),
		.item_count   (item_count),
		.has_current  (has_current),
		.status       (status)
	);

endmodule

// ----- sv/cal_ram.sv -----
// cal_ram: generic single-write, single-read memory with registered read
// no dependencies
module cal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/cal_ctrl.sv -----
// cal_ctrl: command sequencer of the cursor array list
// depends on cal_pkg and cursor_array_list_assert.svh
`include "cursor_array_list_assert.svh"

module cal_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [cal_pkg::CMD_W-1:0] command,
	input  cal_pkg::sts_t             sts,
	output cal_pkg::ctl_t             ctl,
	output logic                      busy,
	output logic                      done
);
	import cal_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_OPEN  = 7'b0000010,
		S_CLOSE = 7'b0000100,
		S_SHIFT = 7'b0001000,
		S_PUT   = 7'b0010000,
		S_LOOK  = 7'b0100000,
		S_SHOW  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   grow_q;
	logic   accept;

	assign accept = (state_q == S_IDLE) && start;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					ctl.capture    = 1'b1;
					ctl.status_set = 1'b1;
					ctl.status     = ST_DONE;
					state_d        = S_LOOK;
					case (command)
						CMD_START: begin
							ctl.cur_zero = 1'b1;
						end
						CMD_ADVANCE: begin
							if (sts.on_item) begin
								ctl.cur_inc = 1'b1;
							end else begin
								ctl.status = ST_NO_ITEM;
							end
						end
						CMD_INSERT: begin
							if (sts.full) begin
								ctl.status = ST_FULL;
							end else begin
								ctl.cur_zero = !sts.on_item;
								state_d      = S_OPEN;
							end
						end
						CMD_ATTACH: begin
							if (sts.full) begin
								ctl.status = ST_FULL;
							end else if (sts.on_item) begin
								ctl.cur_inc = 1'b1;
								state_d     = S_OPEN;
							end else begin
								ctl.cur_end = 1'b1;
								state_d     = S_PUT;
							end
						end
						CMD_REMOVE: begin
							if (sts.on_item) begin
								state_d = S_CLOSE;
							end else begin
								ctl.status = ST_NO_ITEM;
							end
						end
						default: begin
							state_d = S_LOOK;
						end
					endcase
				end
			end
			S_OPEN: begin
				ctl.open_init = 1'b1;
				state_d       = S_SHIFT;
			end
			S_CLOSE: begin
				ctl.close_init = 1'b1;
				ctl.cnt_dec    = 1'b1;
				state_d        = S_SHIFT;
			end
			S_SHIFT: begin
				ctl.shift_run = 1'b1;
				if (sts.shift_done) begin
					state_d = grow_q ? S_PUT : S_LOOK;
				end
			end
			S_PUT: begin
				ctl.put = 1'b1;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = S_SHOW;
			end
			S_SHOW: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			grow_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				grow_q <= (command == CMD_INSERT) || (command == CMD_ATTACH);
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_SHOW);

	`CAL_ASSERT_NEXT(a_accept_busy, accept, busy)
	`CAL_ASSERT_NEXT(a_show_then_idle, done, !busy)
	`CAL_ASSERT_NOW(a_put_only_grow, ctl.put, grow_q)

endmodule

// ----- sv/cal_dp.sv -----
// cal_dp: list datapath with count, cursor, word mover and word memory
// depends on cal_pkg, cal_ram and cursor_array_list_assert.svh
`include "cursor_array_list_assert.svh"

module cal_dp #(
	parameter int CAPACITY_WORDS = cal_pkg::CAPACITY_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [cal_pkg::VALUE_W-1:0]     value,
	input  cal_pkg::ctl_t                   ctl,
	output cal_pkg::sts_t                   sts,
	output logic [cal_pkg::VALUE_W-1:0]     current_value,
	output logic [cal_pkg::COUNT_OUT_W-1:0] item_count,
	output logic                            has_current,
	output logic [cal_pkg::STATUS_W-1:0]    status
);
	import cal_pkg::*;

	localparam int CW = $clog2(CAPACITY_WORDS + 1);
	localparam int AW = $clog2(CAPACITY_WORDS);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY_WORDS);

	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cursor_q;
	status_t            status_q;
	logic [AW-1:0]      rd_q;
	logic [CW-1:0]      left_q;
	logic               up_q;
	logic               mv_s1;
	logic [AW-1:0]      wa_s1;

	logic               on_item;
	logic               move;
	logic [AW-1:0]      cursor_idx;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic [AW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;

	assign on_item    = (cursor_q < count_q);
	assign move       = ctl.shift_run && (left_q != '0);
	assign cursor_idx = cursor_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			cursor_q <= '0;
			status_q <= ST_DONE;
			rd_q     <= '0;
			left_q   <= '0;
			up_q     <= 1'b0;
			mv_s1    <= 1'b0;
		end else begin
			if (ctl.cur_zero) begin
				cursor_q <= '0;
			end else if (ctl.cur_inc) begin
				cursor_q <= cursor_q + CW'(1);
			end else if (ctl.cur_end) begin
				cursor_q <= count_q;
			end
			if (ctl.put) begin
				count_q <= count_q + CW'(1);
			end else if (ctl.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			if (ctl.status_set) begin
				status_q <= ctl.status;
			end
			// open a gap: walk from the top word down to the cursor
			if (ctl.open_init) begin
				rd_q   <= AW'(count_q - CW'(1));
				left_q <= count_q - cursor_q;
				up_q   <= 1'b1;
			// close the gap: walk from the word above the cursor up to the top
			end else if (ctl.close_init) begin
				rd_q   <= AW'(cursor_q + CW'(1));
				left_q <= count_q - cursor_q - CW'(1);
				up_q   <= 1'b0;
			end else if (move) begin
				rd_q   <= up_q ? (rd_q - AW'(1)) : (rd_q + AW'(1));
				left_q <= left_q - CW'(1);
			end
			mv_s1 <= move;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			value_q <= value;
		end
		wa_s1 <= up_q ? (rd_q + AW'(1)) : (rd_q - AW'(1));
	end

	// word read last cycle is written one place up or down
	assign ram_we    = mv_s1 || ctl.put;
	assign ram_waddr = ctl.put ? cursor_idx : wa_s1;
	assign ram_wdata = ctl.put ? value_q : ram_rdata;
	assign ram_raddr = ctl.shift_run ? rd_q : cursor_idx;

	cal_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY_WORDS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign sts.on_item    = on_item;
	assign sts.full       = (count_q == CAP_C);
	assign sts.shift_done = (left_q == '0) && !mv_s1;

	assign current_value = on_item ? ram_rdata : '0;
	assign item_count    = COUNT_OUT_W'(count_q);
	assign has_current   = on_item;
	assign status        = status_q;

	`CAL_ASSERT_NOW(a_cursor_in_list, 1'b1, cursor_q <= count_q)
	`CAL_ASSERT_NOW(a_count_in_cap, 1'b1, count_q <= CAP_C)
	`CAL_ASSERT_NOW(a_move_in_store, mv_s1, 32'(wa_s1) < 32'(CAPACITY_WORDS))

endmodule

// ----- tb/sv/cal_list_checker.sv -----
// cal_list_checker: watches the command and result channels of cursor_array_list,
// keeps its own copy of the list and compares every result field by field
// depends on cal_pkg
module cal_list_checker #(
	parameter int CAPACITY_WORDS = cal_pkg::CAPACITY_WORDS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [cal_pkg::CMD_W-1:0]       command,
	input  logic [cal_pkg::VALUE_W-1:0]     value,
	input  logic                            done,
	input  logic [cal_pkg::VALUE_W-1:0]     current_value,
	input  logic [cal_pkg::COUNT_OUT_W-1:0] item_count,
	input  logic                            has_current,
	input  logic [cal_pkg::STATUS_W-1:0]    status,
	output int                              mismatch_count,
	output int                              reports_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import cal_pkg::*;

	typedef struct packed {
		logic [VALUE_W-1:0]     word;
		logic [COUNT_OUT_W-1:0] count;
		logic                   on_word;
		logic [STATUS_W-1:0]    st;
	} list_report_t;

	logic [VALUE_W-1:0] list_words [CAPACITY_WORDS];
	int unsigned        list_count  = 0;
	int unsigned        list_cursor = 0;
	list_report_t       report_queue [$];
	int                 fails   = 0;
	int                 pending = 0;

	assign mismatch_count  = fails;
	assign reports_pending = pending;

	// shift the words from pos upward by one to free slot pos
	function automatic void make_room(int unsigned pos);
		int unsigned i;
		for (i = list_count; i > pos; i--)
			list_words[i] = list_words[i-1];
	endfunction

	function automatic list_report_t apply_list_command(logic [CMD_W-1:0] code,
	                                                    logic [VALUE_W-1:0] word);
		list_report_t rep;
		status_t      st;
		int unsigned  i;
		st = ST_DONE;
		case (code)
			CMD_START: list_cursor = 0;
			CMD_ADVANCE: begin
				if (list_cursor >= list_count) st = ST_NO_ITEM;
				else list_cursor++;
			end
			CMD_INSERT: begin
				if (list_count >= CAPACITY_WORDS) begin
					st = ST_FULL;
				end else begin
					if (list_cursor >= list_count) list_cursor = 0;
					make_room(list_cursor);
					list_words[list_cursor] = word;
					list_count++;
				end
			end
			CMD_ATTACH: begin
				if (list_count >= CAPACITY_WORDS) begin
					st = ST_FULL;
				end else if (list_cursor >= list_count) begin
					list_cursor = list_count;
					list_words[list_cursor] = word;
					list_count++;
				end else begin
					list_cursor++;
					make_room(list_cursor);
					list_words[list_cursor] = word;
					list_count++;
				end
			end
			CMD_REMOVE: begin
				if (list_cursor >= list_count) begin
					st = ST_NO_ITEM;
				end else begin
					for (i = list_cursor; i + 1 < list_count; i++)
						list_words[i] = list_words[i+1];
					list_count--;
				end
			end
			default: ;
		endcase
		rep.on_word = (list_cursor < list_count);
		rep.word    = rep.on_word ? list_words[list_cursor] : '0;
		rep.count   = COUNT_OUT_W'(list_count);
		rep.st      = st;
		return rep;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			fails++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		list_report_t want;
		if (!arst_n) begin
			list_count  = 0;
			list_cursor = 0;
			report_queue.delete();
		end else begin
			if (done) begin
				if (report_queue.size() == 0) begin
					fails++;
					$display("%0t: unexpected result, expected none actual %0h %0d %0b %0d",
						$time, current_value, item_count, has_current, status);
				end else begin
					want = report_queue.pop_front();
					check_field("current_value", want.word, current_value);
					check_field("item_count", want.count, item_count);
					check_field("has_current", want.on_word, has_current);
					check_field("status", want.st, status);
				end
			end
			if (start && !busy)
				report_queue.push_back(apply_list_command(command, value));
		end
		pending = report_queue.size();
	end

endmodule

// ----- tb/sv/tb.sv -----
// tb: stimulus and verdict for cursor_array_list; directed commands, then random
// runs that fill, drain and wander the list; checking lives in cal_list_checker
// depends on cal_pkg, cursor_array_list and cal_list_checker
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cal_pkg::*;

	localparam int CAPACITY_WORDS = CAPACITY_WORDS_DEF;
	localparam int RESET_CYCLES   = 5;
	localparam int RANDOM_ITEMS   = 1830;
	localparam int MAX_GAP        = 16;
	// slowest item: full shift plus overhead plus the longest sender gap, taken 4x
	localparam int CYCLE_LIMIT    = (RANDOM_ITEMS + 40) * (CAPACITY_WORDS + MAX_GAP + 10) * 4;

	// codes outside the command set, which the block must pass over
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	// command mixes for the random part
	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_WANDER} mix_t;

	logic                   clk    = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   start  = 1'b0;
	logic                   busy;
	logic [CMD_W-1:0]       command = '0;
	logic [VALUE_W-1:0]     value   = '0;
	logic                   done;
	logic [VALUE_W-1:0]     current_value;
	logic [COUNT_OUT_W-1:0] item_count;
	logic                   has_current;
	logic [STATUS_W-1:0]    status;

	int fails;
	int pending;
	int idle_pct = 35;
	int cycles   = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	cursor_array_list #(.CAPACITY_WORDS(CAPACITY_WORDS)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.value         (value),
		.done          (done),
		.current_value (current_value),
		.item_count    (item_count),
		.has_current   (has_current),
		.status        (status)
	);

	cal_list_checker #(.CAPACITY_WORDS(CAPACITY_WORDS)) list_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.command         (command),
		.value           (value),
		.done            (done),
		.current_value   (current_value),
		.item_count      (item_count),
		.has_current     (has_current),
		.status          (status),
		.mismatch_count  (fails),
		.reports_pending (pending)
	);

	// hand one item to the block: optional idle gap, then hold start until taken
	// start is only lowered when a gap follows, so it never toggles within a step
	task automatic issue(input logic [CMD_W-1:0] code, input logic [VALUE_W-1:0] word);
		int gap;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		command <= code;
		value   <= word;
		// busy read right after the edge is the value the block saw at that edge
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// weighted command choice; grow fills the list to the brim so the full
	// rejection shows up, shrink drains it, wander keeps it somewhere between
	function automatic logic [CMD_W-1:0] pick_command(mix_t mix);
		int roll, w_ins, w_att, w_rem, w_adv, w_sta;
		roll = $urandom_range(99);
		case (mix)
			MIX_GROW: begin
				w_ins = 35; w_att = 35; w_rem = 7; w_adv = 12; w_sta = 8;
			end
			MIX_SHRINK: begin
				w_ins = 7; w_att = 10; w_rem = 50; w_adv = 15; w_sta = 15;
			end
			default: begin
				w_ins = 20; w_att = 20; w_rem = 25; w_adv = 20; w_sta = 12;
			end
		endcase
		if (roll < w_ins) return CMD_INSERT;
		roll -= w_ins;
		if (roll < w_att) return CMD_ATTACH;
		roll -= w_att;
		if (roll < w_rem) return CMD_REMOVE;
		roll -= w_rem;
		if (roll < w_adv) return CMD_ADVANCE;
		roll -= w_adv;
		if (roll < w_sta) return CMD_START;
		// the few percent left over go to the unused codes
		return CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
	endfunction

	// mostly random words, now and then all zeros or all ones
	function automatic logic [VALUE_W-1:0] pick_word();
		case ($urandom_range(15))
			0:       return '0;
			1:       return '1;
			default: return $urandom();
		endcase
	endfunction

	initial begin : stimulus
		mix_t mix;
		int   mix_left;
		int   n;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every command on an empty list, then build a short list
		issue(CMD_START, '0);
		issue(CMD_ADVANCE, 32'hFFFF_FFFF);   // no current item, rejected
		issue(CMD_REMOVE, '0);               // no current item, rejected
		issue(CMD_INSERT, 32'h0000_0000);    // empty list, goes to the front
		issue(CMD_ATTACH, 32'hFFFF_FFFF);    // after the current word
		issue(CMD_INSERT, 32'hAAAA_AAAA);    // before the current word
		issue(CMD_ADVANCE, '0);
		issue(CMD_ADVANCE, '0);              // walks off the end
		issue(CMD_ADVANCE, 32'h5555_5555);   // off the end, rejected
		issue(CMD_ATTACH, 32'h5555_5555);    // no current item, goes to the end
		issue(CMD_ADVANCE, '0);
		issue(CMD_INSERT, 32'h1234_5678);    // no current item, goes to the front
		issue(CMD_REMOVE, '0);               // removes the front word
		issue(CMD_ADVANCE, '0);
		issue(CMD_REMOVE, '0);               // middle word, next one becomes current
		issue(CMD_ADVANCE, '0);
		issue(CMD_REMOVE, '0);               // last word, no current item after
		issue(CMD_REMOVE, 32'hFFFF_FFFF);    // rejected
		issue(CMD_SPARE_FIRST, 32'hFFFF_FFFF);
		issue(CMD_SPARE_MID, 32'h5555_5555);
		issue(CMD_SPARE_LAST, 32'hAAAA_AAAA);
		issue(CMD_START, '0);

		// random: grow first so the full list is reached early, then rotate mixes
		mix      = MIX_GROW;
		mix_left = $urandom_range(60, 120);
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// sender idling: 35 percent, then 57 percent, then none at all
			if (n == RANDOM_ITEMS / 3)
				idle_pct = 57;
			if (n == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			if (mix_left == 0) begin
				case (mix)
					MIX_GROW:   mix = MIX_SHRINK;
					MIX_SHRINK: mix = MIX_WANDER;
					default:    mix = MIX_GROW;
				endcase
				mix_left = $urandom_range(40, 120);
			end
			mix_left--;
			issue(pick_command(mix), pick_word());
		end
		start <= 1'b0;

		// drain: sample on the falling edge, clear of the checker's updates
		while (pending != 0)
			@(negedge clk);
		repeat (CAPACITY_WORDS + 10) @(posedge clk);

		if (fails == 0)
			$display("PASS cursor_array_list");
		else
			$display("FAIL cursor_array_list");
		$finish;
	end

	// watchdog against a hung handshake or a lost result
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL cursor_array_list");
			$finish;
		end
	end

endmodule
